/* hdl/rcog_pkg.sv */
// Shared types and constants for the ray cast occupancy grid unit.
// Depends on nothing; every other file but rcog_map_ram refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rcog_pkg;

    // Field widths of the input and result words
    localparam int OPCODE_BITS  = 2;
    localparam int COORD_BITS   = 10;
    localparam int DIR_BITS     = 16;
    localparam int FRAC_BITS    = 14;
    localparam int RANGE_BITS   = 12;
    localparam int OCC_BITS     = 7;
    localparam int TOUCHED_BITS = 13;

    // Beam accumulator holds k * dir; position is its integer part plus the start
    localparam int ACC_BITS = RANGE_BITS + DIR_BITS + 1;
    localparam int POS_BITS = ACC_BITS - FRAC_BITS + 1;

    // Divider produces one quotient bit per step
    localparam int DIV_STEP_BITS = $clog2(OCC_BITS);

    localparam int MAP_SIDE_DEFAULT   = 1024;
    localparam int COUNT_BITS_DEFAULT = 8;

    localparam logic [RANGE_BITS-1:0] RANGE_RESET = 12'd200;
    localparam logic [OCC_BITS-1:0]   UNKNOWN_PCT = 7'd50;
    localparam logic [OCC_BITS-1:0]   FULL_PCT    = 7'd100;
    localparam int                    PCT_SCALE   = 100;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_CAST  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAST_ADDR,
        ST_CAST_WB,
        ST_RD_WAIT,
        ST_RD_DIV,
        ST_CLEAR,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

/* hdl/rcog_req_if.sv */
// Request channel: valid/ready handshake carrying one cast, read or clear word.
// Depends on rcog_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rcog_req_if;
    logic                                     valid;
    logic                                     ready;
    logic [rcog_pkg::OPCODE_BITS-1:0]         opcode;
    logic [rcog_pkg::COORD_BITS-1:0]          cell_x;
    logic [rcog_pkg::COORD_BITS-1:0]          cell_y;
    logic signed [rcog_pkg::DIR_BITS-1:0]     dir_x;
    logic signed [rcog_pkg::DIR_BITS-1:0]     dir_y;
    logic [rcog_pkg::RANGE_BITS-1:0]          obstacle_cells;

    modport source (
        output valid, opcode, cell_x, cell_y, dir_x, dir_y, obstacle_cells,
        input  ready
    );

    modport sink (
        input  valid, opcode, cell_x, cell_y, dir_x, dir_y, obstacle_cells,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/rcog_rsp_if.sv */
// Result channel: valid/ready handshake carrying one result word per request.
// Depends on rcog_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rcog_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [rcog_pkg::OCC_BITS-1:0]        occupancy;
    logic                                 obstacle_marked;
    logic [rcog_pkg::TOUCHED_BITS-1:0]    cells_updated;

    modport source (
        output valid, occupancy, obstacle_marked, cells_updated,
        input  ready
    );

    modport sink (
        input  valid, occupancy, obstacle_marked, cells_updated,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/rcog_map_ram.sv */
// Map memory: one word per cell holding {hit count, visit count}.
// Single write port, single read port with registered read data. No package use.
`timescale 1ns / 1ps
`default_nettype none

module rcog_map_ram #(
    parameter int ADDR_BITS = 20,
    parameter int DATA_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [DATA_BITS-1:0] wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/rcog_div.sv */
// Restoring divider for the occupancy ratio, one quotient bit per cycle.
// Depends on rcog_pkg; caller guarantees num < 2^OCC_BITS * den.
`timescale 1ns / 1ps
`default_nettype none

module rcog_div #(
    parameter int COUNT_BITS = rcog_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic [COUNT_BITS+rcog_pkg::OCC_BITS-1:0] num,
    input  wire logic [COUNT_BITS-1:0]                  den,
    output logic                                        done,
    output logic      [rcog_pkg::OCC_BITS-1:0]          quo
);

    localparam int NUM_BITS = COUNT_BITS + rcog_pkg::OCC_BITS;
    localparam int QB       = rcog_pkg::OCC_BITS;
    localparam int SB       = rcog_pkg::DIV_STEP_BITS;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SB-1:0]     cnt_reg, cnt_next;
    logic [NUM_BITS-1:0] rem_reg, rem_next;
    logic [NUM_BITS-1:0] dsh_reg, dsh_next;
    logic [QB-1:0]     quo_reg, quo_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = SB'(QB - 1);
            rem_next  = num;
            dsh_next  = NUM_BITS'(den) << (QB - 1);
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                quo_next = {quo_reg[QB-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[QB-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

/* hdl/ray_cast_occupancy_grid_unit.sv */
// Top level of the ray cast occupancy grid: beam walker, read path and clear sweep.
// Depends on rcog_pkg, rcog_req_if, rcog_rsp_if, rcog_map_ram and rcog_div.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a saturating hit and visit counter per cell of a MAP_SIDE x MAP_SIDE map in
// one synchronous memory and handles one request word at a time, giving one result
// word per request. A cast costs one read-modify-write of the map memory per cell
// walked, and it walks at most the range limit of cells, stopping on a hit; a read
// goes through the 7-step divider only when the ratio is neither unknown nor full.
// A clear, and the clearing pass after reset, sweeps the whole memory of
// 2^(2*ceil(log2 MAP_SIDE)) entries, 1,048,576 at the default size, one entry per
// cycle with req.ready low. A finished result waits in the output register while the
// next request is taken.
module ray_cast_occupancy_grid_unit #(
    parameter int MAP_SIDE   = rcog_pkg::MAP_SIDE_DEFAULT,
    parameter int COUNT_BITS = rcog_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    rcog_req_if.sink                               req,
    rcog_rsp_if.source                             rsp,
    input  wire logic                              cfg_we,
    input  wire logic [rcog_pkg::RANGE_BITS-1:0]   cfg_wdata
);

    localparam int XW  = $clog2(MAP_SIDE);
    localparam int AW  = 2 * XW;
    localparam int DW  = 2 * COUNT_BITS;
    localparam int NW  = COUNT_BITS + rcog_pkg::OCC_BITS;
    localparam int PW  = rcog_pkg::POS_BITS;
    localparam int ACW = rcog_pkg::ACC_BITS;
    localparam int FB  = rcog_pkg::FRAC_BITS;
    localparam int RB  = rcog_pkg::RANGE_BITS;
    localparam int OB  = rcog_pkg::OCC_BITS;
    localparam int TB  = rcog_pkg::TOUCHED_BITS;
    localparam int DB  = rcog_pkg::DIR_BITS;

    localparam logic signed [PW-1:0]   SIDE_S  = PW'(MAP_SIDE);
    localparam logic [COUNT_BITS-1:0]  CNT_MAX = {COUNT_BITS{1'b1}};

    rcog_pkg::state_t state_reg, state_next;

    logic [RB-1:0]          range_reg, range_next;
    logic                   out_valid_reg, out_valid_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic                   clr_op_reg, clr_op_next;

    logic signed [PW-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic signed [DB-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic signed [ACW-1:0]  accx_reg, accx_next, accy_reg, accy_next;
    logic [RB-1:0]          obst_reg, obst_next;
    logic [RB-1:0]          k_reg, k_next;
    logic [TB-1:0]          touched_reg, touched_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic                   hitstep_reg, hitstep_next;
    logic                   marked_reg, marked_next;
    logic [OB-1:0]          occ_reg, occ_next;
    logic [OB-1:0]          out_occ_reg, out_occ_next;
    logic                   out_marked_reg, out_marked_next;
    logic [TB-1:0]          out_touched_reg, out_touched_next;

    logic signed [PW-1:0]   pos_x, pos_y, rd_x, rd_y;
    logic                   beam_off_map, rd_off_map;
    logic [AW-1:0]          beam_addr, rd_addr;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [DW-1:0]          ram_wdata, ram_rdata;
    logic [COUNT_BITS-1:0]  r_hit, r_vis, w_hit, w_vis;

    logic                   div_start, div_done;
    logic [NW-1:0]          div_num;
    logic [OB-1:0]          div_quo;

    rcog_map_ram #(
        .ADDR_BITS (AW),
        .DATA_BITS (DW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rcog_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (r_vis),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Current beam cell: start plus floor of the accumulated offset
    assign pos_x = sx_reg + $signed({accx_reg[ACW-1], accx_reg[ACW-1:FB]});
    assign pos_y = sy_reg + $signed({accy_reg[ACW-1], accy_reg[ACW-1:FB]});
    assign beam_off_map = pos_x[PW-1] || (pos_x >= SIDE_S) ||
                          pos_y[PW-1] || (pos_y >= SIDE_S);
    assign beam_addr = {pos_y[XW-1:0], pos_x[XW-1:0]};

    assign rd_x = $signed(PW'(req.cell_x));
    assign rd_y = $signed(PW'(req.cell_y));
    assign rd_off_map = (rd_x >= SIDE_S) || (rd_y >= SIDE_S);
    assign rd_addr = {rd_y[XW-1:0], rd_x[XW-1:0]};

    assign r_hit = ram_rdata[DW-1:COUNT_BITS];
    assign r_vis = ram_rdata[COUNT_BITS-1:0];
    assign w_vis = (r_vis != CNT_MAX) ? r_vis + 1'b1 : r_vis;
    assign w_hit = (hitstep_reg && (r_hit != CNT_MAX)) ? r_hit + 1'b1 : r_hit;
    assign div_num = NW'(r_hit) * NW'(rcog_pkg::PCT_SCALE);

    assign ram_raddr = (state_reg == rcog_pkg::ST_IDLE) ? rd_addr : beam_addr;
    assign req.ready = (state_reg == rcog_pkg::ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        range_next       = cfg_we ? cfg_wdata : range_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        clr_addr_next    = clr_addr_reg;
        clr_op_next      = clr_op_reg;
        sx_next          = sx_reg;
        sy_next          = sy_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        accx_next        = accx_reg;
        accy_next        = accy_reg;
        obst_next        = obst_reg;
        k_next           = k_reg;
        touched_next     = touched_reg;
        addr_next        = addr_reg;
        hitstep_next     = hitstep_reg;
        marked_next      = marked_reg;
        occ_next         = occ_reg;
        out_occ_next     = out_occ_reg;
        out_marked_next  = out_marked_reg;
        out_touched_next = out_touched_reg;
        ram_we           = 1'b0;
        ram_waddr        = addr_reg;
        ram_wdata        = {w_hit, w_vis};
        div_start        = 1'b0;

        case (state_reg)
            rcog_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    occ_next     = '0;
                    marked_next  = 1'b0;
                    touched_next = '0;
                    case (rcog_pkg::op_t'(req.opcode))
                        rcog_pkg::OP_CAST:
                        begin
                            sx_next    = rd_x;
                            sy_next    = rd_y;
                            dx_next    = req.dir_x;
                            dy_next    = req.dir_y;
                            obst_next  = req.obstacle_cells;
                            accx_next  = '0;
                            accy_next  = '0;
                            k_next     = '0;
                            state_next = rcog_pkg::ST_CAST_ADDR;
                        end
                        rcog_pkg::OP_READ:
                        begin
                            if (rd_off_map)
                            begin
                                occ_next   = rcog_pkg::UNKNOWN_PCT;
                                state_next = rcog_pkg::ST_EMIT;
                            end
                            else
                            begin
                                state_next = rcog_pkg::ST_RD_WAIT;
                            end
                        end
                        rcog_pkg::OP_CLEAR:
                        begin
                            clr_addr_next = '0;
                            clr_op_next   = 1'b1;
                            state_next    = rcog_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = rcog_pkg::ST_EMIT;
                        end
                    endcase
                end
            end

            rcog_pkg::ST_CAST_ADDR:
            begin
                if (beam_off_map || (k_reg >= range_reg))
                begin
                    state_next = rcog_pkg::ST_EMIT;
                end
                else
                begin
                    addr_next    = beam_addr;
                    hitstep_next = (k_reg >= obst_reg);
                    state_next   = rcog_pkg::ST_CAST_WB;
                end
            end

            // Read data for addr_reg is here; write back before the next address goes out
            rcog_pkg::ST_CAST_WB:
            begin
                ram_we       = 1'b1;
                touched_next = touched_reg + 1'b1;
                if (hitstep_reg)
                begin
                    marked_next = 1'b1;
                    state_next  = rcog_pkg::ST_EMIT;
                end
                else
                begin
                    accx_next  = accx_reg + ACW'(dx_reg);
                    accy_next  = accy_reg + ACW'(dy_reg);
                    k_next     = k_reg + 1'b1;
                    state_next = rcog_pkg::ST_CAST_ADDR;
                end
            end

            rcog_pkg::ST_RD_WAIT:
            begin
                if (r_vis == '0)
                begin
                    occ_next   = rcog_pkg::UNKNOWN_PCT;
                    state_next = rcog_pkg::ST_EMIT;
                end
                else if (r_hit >= r_vis)
                begin
                    occ_next   = rcog_pkg::FULL_PCT;
                    state_next = rcog_pkg::ST_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = rcog_pkg::ST_RD_DIV;
                end
            end

            rcog_pkg::ST_RD_DIV:
            begin
                if (div_done)
                begin
                    occ_next   = div_quo;
                    state_next = rcog_pkg::ST_EMIT;
                end
            end

            rcog_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == {AW{1'b1}})
                begin
                    clr_op_next = 1'b0;
                    state_next  = clr_op_reg ? rcog_pkg::ST_EMIT : rcog_pkg::ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            rcog_pkg::ST_EMIT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_occ_next     = occ_reg;
                    out_marked_next  = marked_reg;
                    out_touched_next = touched_reg;
                    state_next       = rcog_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rcog_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcog_pkg::ST_CLEAR;
            range_reg     <= rcog_pkg::RANGE_RESET;
            out_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
            clr_op_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            range_reg     <= range_next;
            out_valid_reg <= out_valid_next;
            clr_addr_reg  <= clr_addr_next;
            clr_op_reg    <= clr_op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg          <= sx_next;
        sy_reg          <= sy_next;
        dx_reg          <= dx_next;
        dy_reg          <= dy_next;
        accx_reg        <= accx_next;
        accy_reg        <= accy_next;
        obst_reg        <= obst_next;
        k_reg           <= k_next;
        touched_reg     <= touched_next;
        addr_reg        <= addr_next;
        hitstep_reg     <= hitstep_next;
        marked_reg      <= marked_next;
        occ_reg         <= occ_next;
        out_occ_reg     <= out_occ_next;
        out_marked_reg  <= out_marked_next;
        out_touched_reg <= out_touched_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.occupancy       = out_occ_reg;
    assign rsp.obstacle_marked = out_marked_reg;
    assign rsp.cells_updated   = out_touched_reg;

    a_we_only_wb_or_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == rcog_pkg::ST_CAST_WB || state_reg == rcog_pkg::ST_CLEAR))
        else $error("map written outside write-back or clear");

    a_rsp_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rcog_pkg::ST_EMIT))
        else $error("result word loaded outside emit");

    a_touched_tracks_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rcog_pkg::ST_CAST_ADDR) |-> (touched_reg == TB'(k_reg)))
        else $error("touched count out of step with beam index");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == rcog_pkg::ST_RD_DIV))
        else $error("divider finished while not awaited");

    a_occ_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.occupancy <= rcog_pkg::FULL_PCT))
        else $error("occupancy above full scale");

endmodule

`default_nettype wire
